// ----- design/i2crts_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C register transaction sequencer package
// Shared types, item layouts and codes for the sequencer.
// ----------------------------------------------------------------------------
package i2crts_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_EVENT   = 2'd1,
        OP_LOAD    = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_TX    = 3'd3,
        ACT_RX_EN = 3'd4,
        ACT_ACK   = 3'd5,
        ACT_NACK  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PENDING = 2'd1,
        ST_FAILED  = 2'd2
    } status_t;

    typedef enum logic [11:0] {
        PH_ADDR_W    = 12'b0000_0000_0001,
        PH_REG       = 12'b0000_0000_0010,
        PH_DATA      = 12'b0000_0000_0100,
        PH_RESTART   = 12'b0000_0000_1000,
        PH_START     = 12'b0000_0001_0000,
        PH_ADDR_R    = 12'b0000_0010_0000,
        PH_FIRST_RX  = 12'b0000_0100_0000,
        PH_RX_BYTE   = 12'b0000_1000_0000,
        PH_RX_EN     = 12'b0001_0000_0000,
        PH_LAST      = 12'b0010_0000_0000,
        PH_DONE_OK   = 12'b0100_0000_0000,
        PH_DONE_FAIL = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] bus_rx_byte;
        logic       collision;
        logic       nack;
        logic [7:0] buffer_byte;
        logic [4:0] buffer_index;
        logic [5:0] byte_count;
        logic [7:0] register_address;
        logic [6:0] device_address;
        logic       direction;
    } in_item_t;

    typedef struct packed {
        logic [3:0] pad;
        status_t    status;
        logic [7:0] rx_byte;
        logic [4:0] rx_index;
        logic       rx_valid;
        logic [7:0] bus_tx_byte;
        action_t    bus_action;
        logic       accepted;
    } out_item_t;

endpackage

// ----- design/i2c_register_transaction_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C register transaction sequencer
// Steps an I2C master through register write and read transactions.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transaction per item. tuser carries the kind (request, bus
//   completion event, transmit buffer load); tdata carries the fields.
//   m_axis: exactly one result per input item, in order: request accept
//   flag, the next bus action, the byte to transmit, a delivered receive
//   byte with its position, and the transfer status after the item.
//   From input acceptance to result valid an item passes the input
//   register, then the phase update and the result register.
//   Throughput is one item per cycle unless m_axis_tready stalls; the phase
//   and transmit buffer are updated in the same cycle as the result register
//   is loaded, so each item sees the state left by the one before it.
//   The transmit buffer read is registered and addressed by the next byte
//   position, with the load in the same cycle forwarded.
//   Reset leaves the block idle after success with both stages empty.
//   When m_axis_tready is low the result holds and s_axis_tready drops
//   once the input register is also full.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // direction, device_address, register_address, byte_count, buffer_index,
    // buffer_byte, nack, collision, bus_rx_byte, zero fill
    input  logic [i2crts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted, bus_action, bus_tx_byte, rx_valid, rx_index, rx_byte,
    // status, zero fill
    output logic [i2crts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import i2crts_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic [1:0] in_op_reg;

    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;

    phase_t     phase_reg, phase_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] dev_addr_reg, dev_addr_next;
    logic [7:0] target_reg_reg, target_reg_next;
    logic [5:0] total_reg, total_next;
    logic [5:0] byte_pos_reg, byte_pos_next;
    status_t    status_reg, status_next;

    logic [7:0] tx_buffer [BUFFER_DEPTH];
    logic [7:0] tx_rd_reg;
    logic       buf_wr;
    logic [AW-1:0] buf_wa;
    logic [AW-1:0] buf_ra;
    logic [5:0] byte_pos_inc;

    logic out_ready;
    logic proc;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;

    assign byte_pos_inc = byte_pos_reg + 6'd1;
    assign buf_wr = proc && (in_op_reg == OP_LOAD)
                    && ({4'd0, in_item_reg.buffer_index} < DEPTH_W);
    assign buf_wa = AW'(in_item_reg.buffer_index);
    assign buf_ra = AW'(byte_pos_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg <= in_item_t'(s_axis_tdata);
            in_op_reg   <= s_axis_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_wr) begin
            tx_buffer[buf_wa] <= in_item_reg.buffer_byte;
        end
        if (buf_wr && (buf_wa == buf_ra)) begin
            tx_rd_reg <= in_item_reg.buffer_byte;
        end else begin
            tx_rd_reg <= tx_buffer[buf_ra];
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        dev_addr_next   = dev_addr_reg;
        target_reg_next = target_reg_reg;
        total_next      = total_reg;
        byte_pos_next   = byte_pos_reg;
        status_next     = status_reg;
        out_item_next   = '0;

        if (proc) begin
            case (in_op_reg)
                OP_REQUEST: begin
                    if (status_reg != ST_PENDING
                        && {3'd0, in_item_reg.byte_count} <= DEPTH_W) begin
                        out_item_next.accepted   = 1'b1;
                        out_item_next.bus_action = ACT_START;
                        is_read_next    = in_item_reg.direction;
                        dev_addr_next   = {in_item_reg.device_address, 1'b0};
                        target_reg_next = in_item_reg.register_address;
                        total_next      = in_item_reg.byte_count;
                        byte_pos_next   = 6'd0;
                        status_next     = ST_PENDING;
                        phase_next      = PH_ADDR_W;
                    end
                end
                OP_EVENT: begin
                    if (in_item_reg.collision) begin
                        out_item_next.bus_action = ACT_STOP;
                        phase_next = PH_DONE_FAIL;
                    end else begin
                        unique case (phase_reg)
                            PH_ADDR_W: begin
                                out_item_next.bus_action  = ACT_TX;
                                out_item_next.bus_tx_byte = dev_addr_reg;
                                phase_next = PH_REG;
                            end
                            PH_REG: begin
                                if (in_item_reg.nack) begin
                                    out_item_next.bus_action = ACT_STOP;
                                    phase_next = PH_DONE_FAIL;
                                end else begin
                                    out_item_next.bus_action  = ACT_TX;
                                    out_item_next.bus_tx_byte = target_reg_reg;
                                    phase_next = is_read_reg ? PH_RESTART : PH_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (in_item_reg.nack) begin
                                    out_item_next.bus_action = ACT_STOP;
                                    phase_next = PH_DONE_FAIL;
                                end else if (byte_pos_reg < total_reg) begin
                                    out_item_next.bus_action  = ACT_TX;
                                    out_item_next.bus_tx_byte = tx_rd_reg;
                                    byte_pos_next = byte_pos_inc;
                                end else begin
                                    out_item_next.bus_action = ACT_STOP;
                                    phase_next = PH_DONE_OK;
                                end
                            end
                            PH_RESTART: begin
                                out_item_next.bus_action = ACT_STOP;
                                phase_next = in_item_reg.nack ? PH_DONE_FAIL : PH_START;
                            end
                            PH_START: begin
                                out_item_next.bus_action = ACT_START;
                                phase_next = PH_ADDR_R;
                            end
                            PH_ADDR_R: begin
                                out_item_next.bus_action  = ACT_TX;
                                out_item_next.bus_tx_byte = {dev_addr_reg[7:1], 1'b1};
                                phase_next = PH_FIRST_RX;
                            end
                            PH_FIRST_RX: begin
                                if (in_item_reg.nack) begin
                                    out_item_next.bus_action = ACT_STOP;
                                    phase_next = PH_DONE_FAIL;
                                end else begin
                                    out_item_next.bus_action = ACT_RX_EN;
                                    phase_next = PH_RX_BYTE;
                                end
                            end
                            PH_RX_BYTE: begin
                                out_item_next.rx_valid = 1'b1;
                                out_item_next.rx_index = byte_pos_reg[4:0];
                                out_item_next.rx_byte  = in_item_reg.bus_rx_byte;
                                byte_pos_next = byte_pos_inc;
                                if (byte_pos_inc < total_reg) begin
                                    out_item_next.bus_action = ACT_ACK;
                                    phase_next = PH_RX_EN;
                                end else begin
                                    out_item_next.bus_action = ACT_NACK;
                                    phase_next = PH_LAST;
                                end
                            end
                            PH_RX_EN: begin
                                out_item_next.bus_action = ACT_RX_EN;
                                phase_next = PH_RX_BYTE;
                            end
                            PH_LAST: begin
                                out_item_next.bus_action = ACT_STOP;
                                phase_next = PH_DONE_OK;
                            end
                            PH_DONE_OK: begin
                                status_next = ST_OK;
                            end
                            default: begin
                                phase_next  = PH_DONE_FAIL;
                                status_next = ST_FAILED;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
        out_item_next.status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_DONE_OK;
            is_read_reg    <= 1'b0;
            dev_addr_reg   <= 8'd0;
            target_reg_reg <= 8'd0;
            total_reg      <= 6'd0;
            byte_pos_reg   <= 6'd0;
            status_reg     <= ST_OK;
        end else begin
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            dev_addr_reg   <= dev_addr_next;
            target_reg_reg <= target_reg_next;
            total_reg      <= total_next;
            byte_pos_reg   <= byte_pos_next;
            status_reg     <= status_next;
        end
        if (proc) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ----- tb/i2c_register_transaction_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer testbench
// Drives requests, bus completion events and transmit buffer loads into the
// sequencer with random gaps on both streams. Each accepted item is fed to a
// local model of the sequencer; every result is checked in order against it.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_test;

    import i2crts_pkg::*;

    localparam int          DEPTH     = 32;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    class sequencer_scoreboard;
        phase_t      phase;
        bit          is_read;
        logic [7:0]  dev_shifted;
        logic [7:0]  target_reg;
        logic [5:0]  total_bytes;
        logic [5:0]  byte_pos;
        status_t     xfer_status;
        logic [7:0]  tx_buf [DEPTH];
        out_item_t   expected_steps[$];
        int          mismatches;
        int          results_seen;

        function new();
            phase        = PH_DONE_OK;
            is_read      = 1'b0;
            dev_shifted  = '0;
            target_reg   = '0;
            total_bytes  = '0;
            byte_pos     = '0;
            xfer_status  = ST_OK;
            mismatches   = 0;
            results_seen = 0;
            foreach (tx_buf[i]) tx_buf[i] = '0;
        endfunction

        // advance the sequencer model by one accepted item
        function void take_item(logic [1:0] op, in_item_t it);
            out_item_t r;
            bit        abort;
            r     = '0;
            abort = 1'b0;
            case (op)
                OP_REQUEST: begin
                    if (xfer_status != ST_PENDING && it.byte_count <= DEPTH) begin
                        r.accepted   = 1'b1;
                        is_read      = it.direction;
                        dev_shifted  = {it.device_address, 1'b0};
                        target_reg   = it.register_address;
                        total_bytes  = it.byte_count;
                        byte_pos     = '0;
                        xfer_status  = ST_PENDING;
                        phase        = PH_ADDR_W;
                        r.bus_action = ACT_START;
                    end
                end
                OP_LOAD: tx_buf[it.buffer_index] = it.buffer_byte;
                OP_EVENT: begin
                    if (it.collision) begin
                        abort = 1'b1;
                    end else begin
                        case (phase)
                            PH_ADDR_W: begin
                                r.bus_action  = ACT_TX;
                                r.bus_tx_byte = dev_shifted;
                                phase         = PH_REG;
                            end
                            PH_REG: begin
                                if (it.nack) begin
                                    abort = 1'b1;
                                end else begin
                                    r.bus_action  = ACT_TX;
                                    r.bus_tx_byte = target_reg;
                                    phase         = is_read ? PH_RESTART : PH_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (it.nack) begin
                                    abort = 1'b1;
                                end else if (byte_pos < total_bytes) begin
                                    r.bus_action  = ACT_TX;
                                    r.bus_tx_byte = tx_buf[byte_pos[4:0]];
                                    byte_pos      = byte_pos + 6'd1;
                                end else begin
                                    r.bus_action = ACT_STOP;
                                    phase        = PH_DONE_OK;
                                end
                            end
                            PH_RESTART: begin
                                if (it.nack) begin
                                    abort = 1'b1;
                                end else begin
                                    r.bus_action = ACT_STOP;
                                    phase        = PH_START;
                                end
                            end
                            PH_START: begin
                                r.bus_action = ACT_START;
                                phase        = PH_ADDR_R;
                            end
                            PH_ADDR_R: begin
                                r.bus_action  = ACT_TX;
                                r.bus_tx_byte = dev_shifted | 8'h01;
                                phase         = PH_FIRST_RX;
                            end
                            PH_FIRST_RX: begin
                                if (it.nack) begin
                                    abort = 1'b1;
                                end else begin
                                    r.bus_action = ACT_RX_EN;
                                    phase        = PH_RX_BYTE;
                                end
                            end
                            PH_RX_BYTE: begin
                                r.rx_valid = 1'b1;
                                r.rx_index = byte_pos[4:0];
                                r.rx_byte  = it.bus_rx_byte;
                                byte_pos   = byte_pos + 6'd1;
                                if (byte_pos < total_bytes) begin
                                    r.bus_action = ACT_ACK;
                                    phase        = PH_RX_EN;
                                end else begin
                                    r.bus_action = ACT_NACK;
                                    phase        = PH_LAST;
                                end
                            end
                            PH_RX_EN: begin
                                r.bus_action = ACT_RX_EN;
                                phase        = PH_RX_BYTE;
                            end
                            PH_LAST: begin
                                r.bus_action = ACT_STOP;
                                phase        = PH_DONE_OK;
                            end
                            PH_DONE_OK: xfer_status = ST_OK;
                            default: begin
                                phase       = PH_DONE_FAIL;
                                xfer_status = ST_FAILED;
                            end
                        endcase
                    end
                    if (abort) begin
                        r.bus_action = ACT_STOP;
                        phase        = PH_DONE_FAIL;
                    end
                end
                default: ;
            endcase
            r.status = xfer_status;
            expected_steps.push_back(r);
        endfunction

        function void note_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h", results_seen, what, exp_v,
                         got_v);
        endfunction

        function void check_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) note_mismatch(what, exp_v, got_v);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            out_item_t got;
            out_item_t exp_r;
            got = data;
            results_seen++;
            if (expected_steps.size() == 0) begin
                note_mismatch("unexpected result, tdata low byte", 8'h00, data[7:0]);
                return;
            end
            exp_r = expected_steps.pop_front();
            check_field("accepted",    exp_r.accepted,    got.accepted);
            check_field("bus_action",  exp_r.bus_action,  got.bus_action);
            check_field("bus_tx_byte", exp_r.bus_tx_byte, got.bus_tx_byte);
            check_field("rx_valid",    exp_r.rx_valid,    got.rx_valid);
            check_field("rx_index",    exp_r.rx_index,    got.rx_index);
            check_field("rx_byte",     exp_r.rx_byte,     got.rx_byte);
            check_field("status",      exp_r.status,      got.status);
            check_field("zero fill",   exp_r.pad,         got.pad);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    sequencer_scoreboard    sb = new();
    bit                     slot_loaded [DEPTH];
    bit                     sender_steady;
    bit                     held_off;
    int                     items_sent;

    i2c_register_transaction_sequencer #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(s_axis_tuser, in_item_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom % 100;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it                  = '0;
        it.direction        = 1'($urandom);
        it.device_address   = 7'($urandom);
        it.register_address = 8'($urandom);
        it.byte_count       = 6'($urandom);
        it.buffer_index     = 5'($urandom);
        it.buffer_byte      = 8'($urandom);
        it.nack             = 1'($urandom);
        it.collision        = 1'($urandom);
        it.bus_rx_byte      = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input logic [1:0] op, input in_item_t it);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_load(input int idx, input logic [7:0] val);
        in_item_t it;
        it              = rand_item();
        it.buffer_index = 5'(idx);
        it.buffer_byte  = val;
        slot_loaded[idx] = 1'b1;
        send_item(OP_LOAD, it);
    endtask

    task automatic send_event(input bit nack, input bit coll);
        in_item_t it;
        it           = rand_item();
        it.nack      = nack;
        it.collision = coll;
        send_item(OP_EVENT, it);
    endtask

    // a write may read any slot below its count, so those get loaded first
    task automatic send_request(input bit dir, input logic [6:0] dev, input logic [7:0] raddr,
                                input logic [5:0] cnt);
        in_item_t it;
        if (!dir && cnt <= DEPTH) begin
            for (int i = 0; i < cnt; i++)
                if (!slot_loaded[i]) send_load(i, 8'($urandom));
        end
        it                  = rand_item();
        it.direction        = dir;
        it.device_address   = dev;
        it.register_address = raddr;
        it.byte_count       = cnt;
        send_item(OP_REQUEST, it);
    endtask

    task automatic run_random_transfer();
        bit         dir;
        logic [5:0] cnt;
        int         r;
        int         n_events;
        r   = $urandom % 100;
        dir = 1'($urandom);
        if (r < 80)      cnt = 6'($urandom_range(0, 4));
        else if (r < 95) cnt = 6'($urandom_range(5, DEPTH));
        else             cnt = 6'($urandom_range(DEPTH + 1, 63));
        sender_steady = ($urandom % 4 == 0);
        send_request(dir, 7'($urandom), 8'($urandom), cnt);
        if (dir) n_events = 2 * ((cnt == 0) ? 1 : cnt) + 7;
        else     n_events = cnt + 4;
        n_events += $urandom_range(0, 2);
        for (int i = 0; i < n_events; i++) begin
            if ($urandom % 20 == 0) send_load($urandom_range(0, DEPTH - 1), 8'($urandom));
            if ($urandom % 40 == 0)
                send_request(1'($urandom), 7'($urandom), 8'($urandom), 6'($urandom));
            if ($urandom % 80 == 0) send_item(OP_UNUSED, rand_item());
            send_event($urandom % 40 == 0, $urandom % 60 == 0);
        end
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        held_off = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held_off && sb.results_seen >= 150) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                int stall;
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin
        int waited;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_REQUEST;
        sender_steady = 1'b0;
        items_sent    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // collision while idle, then the event that records the failure
        send_event(1'b0, 1'b1);
        send_event(1'b0, 1'b0);
        send_item(OP_UNUSED, rand_item());
        send_load(0, 8'hFF);
        send_load(DEPTH - 1, 8'h00);
        send_request(1'b0, 7'h7F, 8'hFF, 6'd63);

        // one-byte write at the top addresses, with a request while busy
        send_request(1'b0, 7'h7F, 8'hFF, 6'd1);
        send_request(1'b1, 7'h00, 8'h00, 6'd0);
        repeat (5) send_event(1'b0, 1'b0);
        send_event(1'b0, 1'b0);

        // zero-length read still takes one byte
        send_request(1'b1, 7'h00, 8'h00, 6'd0);
        repeat (9) send_event(1'b0, 1'b0);

        // read refused on the device address
        send_request(1'b1, 7'h55, 8'hAA, 6'd2);
        send_event(1'b0, 1'b0);
        send_event(1'b1, 1'b0);
        send_event(1'b0, 1'b0);

        items_sent = 0;
        while (items_sent < 500) run_random_transfer();
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.expected_steps.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_steps.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
